// ===== rtl/pwm_input_capture_meter_macros.svh =====
// ---------------------------------------------------------------------------
// pwm_input_capture_meter_macros
// Assertion macros used by the checker file of the capture meter.
// ---------------------------------------------------------------------------
`ifndef PWM_INPUT_CAPTURE_METER_MACROS_SVH
`define PWM_INPUT_CAPTURE_METER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define PWMICM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define PWMICM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pwmicm_pkg.sv =====
// ---------------------------------------------------------------------------
// pwmicm_pkg
// Widths, constants, register indexes and types of the capture meter.
// ---------------------------------------------------------------------------
package pwmicm_pkg;

	// Field widths
	localparam int CAP_W   = 16;
	localparam int OVF_W   = 32;
	localparam int STAMP_W = 32;
	localparam int CLK_W   = 27;
	localparam int FREQ_W  = 34;
	localparam int TIME_W  = 32;
	localparam int DUTY_W  = 14;

	// Datapath widths: P is the 33-bit period in ticks (high plus low ticks in complex mode)
	localparam int P_W    = 33;
	localparam int SCL_W  = 27;
	localparam int NUM_W  = P_W + SCL_W;
	localparam int QUO_W  = 34;
	localparam int DVD_W  = 34;
	localparam int STEP_W = 6;

	// Iteration counts of the divider per kind of quotient
	localparam logic [STEP_W-1:0] STEPS_FREQ = STEP_W'(FREQ_W);
	localparam logic [STEP_W-1:0] STEPS_TIME = STEP_W'(TIME_W + 1);
	localparam logic [STEP_W-1:0] STEPS_DUTY = STEP_W'(DUTY_W);

	// Scale factors
	localparam logic [SCL_W-1:0] SCALE_CENTI = SCL_W'(100);
	localparam logic [SCL_W-1:0] SCALE_10NS  = SCL_W'(100000000);
	localparam logic [SCL_W-1:0] SCALE_DUTY  = SCL_W'(10000);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(48000000);

	// Configuration register indexes
	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_TIMER_CLOCK = 1'b0;
	localparam logic [IDX_W-1:0] REG_MEASURE_MODE = 1'b1;

	localparam logic MODE_SIMPLE  = 1'b0;
	localparam logic MODE_COMPLEX = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LOAD,
		ST_KICK,
		ST_WAIT,
		ST_PUB
	} st_t;

	// Quotients worked out per item, in order
	typedef enum logic [2:0] {
		OP_FREQ,
		OP_PERIOD,
		OP_HIGH,
		OP_LOW,
		OP_HDUTY,
		OP_LDUTY
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic eval;
		logic load;
		logic div_start;
		logic store;
		logic store_sat;
		logic publish;
		op_t  op;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic meas_ok;
		logic mode;
		logic sat;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic is_time(op_t op);
		return (op == OP_PERIOD) || (op == OP_HIGH) || (op == OP_LOW);
	endfunction

	function automatic op_t next_op(op_t op);
		op_t n;
		unique case (op)
			OP_FREQ:   n = OP_PERIOD;
			OP_PERIOD: n = OP_HIGH;
			OP_HIGH:   n = OP_LOW;
			OP_LOW:    n = OP_HDUTY;
			OP_HDUTY:  n = OP_LDUTY;
			default:   n = OP_FREQ;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/pwmicm_if.sv =====
// ---------------------------------------------------------------------------
// pwmicm_if
// Valid/ready channels of the capture meter: capture events in, results out.
// ---------------------------------------------------------------------------
interface pwmicm_evt_if;
	logic                             valid;
	logic                             ready;
	logic [pwmicm_pkg::CAP_W-1:0]     capture_count;
	logic [pwmicm_pkg::OVF_W-1:0]     overflow_ticks;

	modport source (output valid, capture_count, overflow_ticks, input ready);
	modport sink   (input valid, capture_count, overflow_ticks, output ready);
endinterface

interface pwmicm_res_if;
	logic                             valid;
	logic                             ready;
	logic                             result_valid;
	logic [pwmicm_pkg::FREQ_W-1:0]    frequency_centihz;
	logic [pwmicm_pkg::TIME_W-1:0]    period_10ns;
	logic [pwmicm_pkg::TIME_W-1:0]    high_time_10ns;
	logic [pwmicm_pkg::TIME_W-1:0]    low_time_10ns;
	logic [pwmicm_pkg::DUTY_W-1:0]    high_duty_centipct;
	logic [pwmicm_pkg::DUTY_W-1:0]    low_duty_centipct;
	logic                             next_edge_rising;

	modport source (output valid, result_valid, frequency_centihz, period_10ns,
		high_time_10ns, low_time_10ns, high_duty_centipct, low_duty_centipct,
		next_edge_rising, input ready);
	modport sink   (input valid, result_valid, frequency_centihz, period_10ns,
		high_time_10ns, low_time_10ns, high_duty_centipct, low_duty_centipct,
		next_edge_rising, output ready);
endinterface

// ===== rtl/pwmicm_div.sv =====
// ---------------------------------------------------------------------------
// pwmicm_div
// Restoring divider, one quotient bit per cycle, shared by all quotients.
// ---------------------------------------------------------------------------
module pwmicm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pwmicm_pkg::P_W-1:0]          rem_init,
	input  logic [pwmicm_pkg::DVD_W-1:0]        dividend,
	input  logic [pwmicm_pkg::P_W-1:0]          divisor,
	input  logic [pwmicm_pkg::STEP_W-1:0]       steps,
	output logic                                done,
	output logic [pwmicm_pkg::QUO_W-1:0]        quotient
);

	logic                              busy_q;
	logic [pwmicm_pkg::STEP_W-1:0]     cnt_q;
	logic [pwmicm_pkg::P_W-1:0]        rem_q;
	logic [pwmicm_pkg::DVD_W-1:0]      dvd_q;
	logic [pwmicm_pkg::P_W-1:0]        dvs_q;
	logic [pwmicm_pkg::QUO_W-1:0]      quo_q;

	logic [pwmicm_pkg::P_W:0]          trial;
	logic [pwmicm_pkg::P_W:0]          diff;
	logic                              ge;

	// One compare-subtract step; remainder stays below the divisor
	always_comb begin
		trial = {rem_q, dvd_q[pwmicm_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control: busy while steps remain, done for one cycle at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[pwmicm_pkg::P_W-1:0] : trial[pwmicm_pkg::P_W-1:0];
			dvd_q <= {dvd_q[pwmicm_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[pwmicm_pkg::QUO_W-2:0], ge};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

// ===== rtl/pwmicm_dp.sv =====
// ---------------------------------------------------------------------------
// pwmicm_dp
// Datapath: configuration, edge timing state, scaling multiplier, divider
// set-up, working results and the output register.
// ---------------------------------------------------------------------------
module pwmicm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [pwmicm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pwmicm_pkg::CLK_W-1:0]        cfg_data,
	// event payload
	input  logic [pwmicm_pkg::CAP_W-1:0]        capture_count,
	input  logic [pwmicm_pkg::OVF_W-1:0]        overflow_ticks,
	// result channel
	input  logic                                res_ready,
	output logic                                res_valid,
	output logic                                result_valid,
	output logic [pwmicm_pkg::FREQ_W-1:0]       frequency_centihz,
	output logic [pwmicm_pkg::TIME_W-1:0]       period_10ns,
	output logic [pwmicm_pkg::TIME_W-1:0]       high_time_10ns,
	output logic [pwmicm_pkg::TIME_W-1:0]       low_time_10ns,
	output logic [pwmicm_pkg::DUTY_W-1:0]       high_duty_centipct,
	output logic [pwmicm_pkg::DUTY_W-1:0]       low_duty_centipct,
	output logic                                next_edge_rising,
	// controller
	input  pwmicm_pkg::cmd_t                    cmd,
	output pwmicm_pkg::sts_t                    sts
);

	localparam int PW = pwmicm_pkg::P_W;
	localparam int NW = pwmicm_pkg::NUM_W;
	localparam int TW = pwmicm_pkg::TIME_W;
	localparam int DW = pwmicm_pkg::DUTY_W;
	localparam int CW = pwmicm_pkg::CLK_W;

	// Configuration
	logic [CW-1:0]                       clk_hz_q;
	logic                                mode_q;
	// Edge timing state
	logic [pwmicm_pkg::STAMP_W-1:0]      last_q;
	logic                                armed_q;
	logic [TW-1:0]                       high_q;
	logic [TW-1:0]                       low_q;
	logic [TW-1:0]                       period_q;
	// Per-item working registers
	logic [PW-1:0]                       p_q;
	logic [NW-1:0]                       num_q;
	logic                                w_valid_q;
	logic [pwmicm_pkg::FREQ_W-1:0]       w_freq_q;
	logic [TW-1:0]                       w_period_q;
	logic [TW-1:0]                       w_high_q;
	logic [TW-1:0]                       w_low_q;
	logic [DW-1:0]                       w_hduty_q;
	logic [DW-1:0]                       w_lduty_q;
	// Output register
	logic                                ov_q;
	logic                                o_valid_q;
	logic [pwmicm_pkg::FREQ_W-1:0]       o_freq_q;
	logic [TW-1:0]                       o_period_q;
	logic [TW-1:0]                       o_high_q;
	logic [TW-1:0]                       o_low_q;
	logic [DW-1:0]                       o_hduty_q;
	logic [DW-1:0]                       o_lduty_q;
	logic                                o_edge_q;

	logic [pwmicm_pkg::STAMP_W:0]        stamp_sum;
	logic [pwmicm_pkg::STAMP_W-1:0]      delta;
	logic [PW-1:0]                       p_c;
	logic                                meas_ok;
	logic [PW-1:0]                       mul_a;
	logic [pwmicm_pkg::SCL_W-1:0]        mul_b;
	logic [NW-1:0]                       product;
	logic [PW-1:0]                       d_rem;
	logic [pwmicm_pkg::DVD_W-1:0]        d_dvd;
	logic [PW-1:0]                       d_dvs;
	logic [pwmicm_pkg::STEP_W-1:0]       d_steps;
	logic                                d_done;
	logic [pwmicm_pkg::QUO_W-1:0]        d_quo;
	logic [TW-1:0]                       time_q;
	logic                                out_free;

	// Timestamp and interval since the previous edge, both modulo 2^32
	always_comb begin
		stamp_sum = {1'b0, overflow_ticks} + {(pwmicm_pkg::STAMP_W + 1 - pwmicm_pkg::CAP_W)'(0),
			capture_count};
		delta     = stamp_sum[pwmicm_pkg::STAMP_W-1:0] - last_q;
	end

	// Period denominator and validity from the updated state
	always_comb begin
		p_c     = (mode_q == pwmicm_pkg::MODE_COMPLEX) ? ({1'b0, high_q} + {1'b0, low_q})
			: {1'b0, period_q};
		meas_ok = (clk_hz_q != '0) && ((mode_q == pwmicm_pkg::MODE_COMPLEX)
			? ((high_q != '0) && (low_q != '0)) : (period_q != '0));
	end

	// Scaling multiplier operands per quotient
	always_comb begin
		unique case (cmd.op)
			pwmicm_pkg::OP_FREQ: begin
				mul_a = {(PW - CW)'(0), clk_hz_q};
				mul_b = pwmicm_pkg::SCALE_CENTI;
			end
			pwmicm_pkg::OP_PERIOD: begin
				mul_a = p_q;
				mul_b = pwmicm_pkg::SCALE_10NS;
			end
			pwmicm_pkg::OP_HIGH: begin
				mul_a = {1'b0, high_q};
				mul_b = pwmicm_pkg::SCALE_10NS;
			end
			pwmicm_pkg::OP_LOW: begin
				mul_a = {1'b0, low_q};
				mul_b = pwmicm_pkg::SCALE_10NS;
			end
			pwmicm_pkg::OP_HDUTY: begin
				mul_a = {1'b0, high_q};
				mul_b = pwmicm_pkg::SCALE_DUTY;
			end
			default: begin
				mul_a = {1'b0, low_q};
				mul_b = pwmicm_pkg::SCALE_DUTY;
			end
		endcase
		product = {(NW - PW)'(0), mul_a} * {(NW - pwmicm_pkg::SCL_W)'(0), mul_b};
	end

	// Divider set-up: upper numerator bits seed the remainder where the
	// quotient is known to be short
	always_comb begin
		if (cmd.op == pwmicm_pkg::OP_FREQ) begin
			d_rem   = '0;
			d_dvd   = num_q[pwmicm_pkg::DVD_W-1:0];
			d_dvs   = p_q;
			d_steps = pwmicm_pkg::STEPS_FREQ;
		end else if (pwmicm_pkg::is_time(cmd.op)) begin
			d_rem   = {(PW - (NW - TW - 1))'(0), num_q[NW-1:TW+1]};
			d_dvd   = {num_q[TW:0], 1'b0};
			d_dvs   = {(PW - CW)'(0), clk_hz_q};
			d_steps = pwmicm_pkg::STEPS_TIME;
		end else begin
			// duty numerator stays below P * 2^14, so its upper bits fit P
			d_rem   = num_q[DW+PW-1:DW];
			d_dvd   = {num_q[DW-1:0], (pwmicm_pkg::DVD_W - DW)'(0)};
			d_dvs   = p_q;
			d_steps = pwmicm_pkg::STEPS_DUTY;
		end
	end

	pwmicm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (d_rem),
		.dividend (d_dvd),
		.divisor  (d_dvs),
		.steps    (d_steps),
		.done     (d_done),
		.quotient (d_quo)
	);

	// Time quotient saturates at 2^32-1
	assign time_q   = (cmd.store_sat || d_quo[TW]) ? '1 : d_quo[TW-1:0];
	assign out_free = !ov_q || res_ready;

	// Status for the controller
	always_comb begin
		sts.meas_ok  = meas_ok;
		sts.mode     = mode_q;
		sts.sat      = pwmicm_pkg::is_time(cmd.op)
			&& (num_q[NW-1:TW+1] >= clk_hz_q);
		sts.div_done = d_done;
		sts.out_free = out_free;
	end

	// Configuration and edge timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= pwmicm_pkg::CLK_RESET;
			mode_q   <= pwmicm_pkg::MODE_SIMPLE;
			last_q   <= '0;
			armed_q  <= 1'b0;
			high_q   <= '0;
			low_q    <= '0;
			period_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pwmicm_pkg::REG_TIMER_CLOCK:  clk_hz_q <= cfg_data;
					pwmicm_pkg::REG_MEASURE_MODE: mode_q   <= cfg_data[0];
					default:                      ;
				endcase
			end
			if (cmd.accept) begin
				last_q <= stamp_sum[pwmicm_pkg::STAMP_W-1:0];
				if (mode_q == pwmicm_pkg::MODE_SIMPLE) begin
					period_q <= delta;
				end else if (!armed_q) begin
					high_q  <= delta;
					armed_q <= 1'b1;
				end else begin
					low_q   <= delta;
					armed_q <= 1'b0;
				end
			end
		end
	end

	// Working results
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			p_q        <= p_c;
			w_valid_q  <= meas_ok;
			w_freq_q   <= '0;
			w_period_q <= '0;
			w_high_q   <= '0;
			w_low_q    <= '0;
			w_hduty_q  <= '0;
			w_lduty_q  <= '0;
		end
		if (cmd.load) begin
			num_q <= product;
		end
		if (cmd.store) begin
			unique case (cmd.op)
				pwmicm_pkg::OP_FREQ:   w_freq_q   <= d_quo;
				pwmicm_pkg::OP_PERIOD: w_period_q <= time_q;
				pwmicm_pkg::OP_HIGH:   w_high_q   <= time_q;
				pwmicm_pkg::OP_LOW:    w_low_q    <= time_q;
				pwmicm_pkg::OP_HDUTY:  w_hduty_q  <= d_quo[DW-1:0];
				default:               w_lduty_q  <= d_quo[DW-1:0];
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.publish) begin
			ov_q <= 1'b1;
		end else if (res_ready) begin
			ov_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			o_valid_q  <= w_valid_q;
			o_freq_q   <= w_freq_q;
			o_period_q <= w_period_q;
			o_high_q   <= w_high_q;
			o_low_q    <= w_low_q;
			o_hduty_q  <= w_hduty_q;
			o_lduty_q  <= w_lduty_q;
			o_edge_q   <= armed_q;
		end
	end

	assign res_valid          = ov_q;
	assign result_valid       = o_valid_q;
	assign frequency_centihz  = o_freq_q;
	assign period_10ns        = o_period_q;
	assign high_time_10ns     = o_high_q;
	assign low_time_10ns      = o_low_q;
	assign high_duty_centipct = o_hduty_q;
	assign low_duty_centipct  = o_lduty_q;
	assign next_edge_rising   = o_edge_q;

endmodule

// ===== rtl/pwmicm_ctrl.sv =====
// ---------------------------------------------------------------------------
// pwmicm_ctrl
// Controller: takes an event, steps the datapath through the quotients of its
// mode (none if invalid) and hands the result to the output register.
// ---------------------------------------------------------------------------
module pwmicm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_ready,
	input  pwmicm_pkg::sts_t     sts,
	output pwmicm_pkg::cmd_t     cmd
);

	pwmicm_pkg::st_t  st_q, st_d;
	pwmicm_pkg::op_t  op_q, op_d;
	logic             last_op;

	// State and quotient index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pwmicm_pkg::ST_IDLE;
			op_q <= pwmicm_pkg::OP_FREQ;
		end else begin
			st_q <= st_d;
			op_q <= op_d;
		end
	end

	// Simple mode stops after the period
	assign last_op = (op_q == pwmicm_pkg::OP_LDUTY)
		|| ((op_q == pwmicm_pkg::OP_PERIOD) && (sts.mode == pwmicm_pkg::MODE_SIMPLE));

	// Next state and commands
	always_comb begin
		st_d      = st_q;
		op_d      = op_q;
		evt_ready = 1'b0;
		cmd       = '0;
		cmd.op    = op_q;
		unique case (st_q)
			pwmicm_pkg::ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.accept = 1'b1;
					st_d       = pwmicm_pkg::ST_EVAL;
				end
			end
			pwmicm_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.meas_ok) begin
					op_d = pwmicm_pkg::OP_FREQ;
					st_d = pwmicm_pkg::ST_LOAD;
				end else begin
					st_d = pwmicm_pkg::ST_PUB;
				end
			end
			pwmicm_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				st_d     = pwmicm_pkg::ST_KICK;
			end
			pwmicm_pkg::ST_KICK: begin
				if (sts.sat) begin
					cmd.store     = 1'b1;
					cmd.store_sat = 1'b1;
					if (last_op) begin
						st_d = pwmicm_pkg::ST_PUB;
					end else begin
						op_d = pwmicm_pkg::next_op(op_q);
						st_d = pwmicm_pkg::ST_LOAD;
					end
				end else begin
					cmd.div_start = 1'b1;
					st_d          = pwmicm_pkg::ST_WAIT;
				end
			end
			pwmicm_pkg::ST_WAIT: begin
				if (sts.div_done) begin
					cmd.store = 1'b1;
					if (last_op) begin
						st_d = pwmicm_pkg::ST_PUB;
					end else begin
						op_d = pwmicm_pkg::next_op(op_q);
						st_d = pwmicm_pkg::ST_LOAD;
					end
				end
			end
			pwmicm_pkg::ST_PUB: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					st_d        = pwmicm_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = pwmicm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/pwm_input_capture_meter.sv =====
// ---------------------------------------------------------------------------
// pwm_input_capture_meter
// Frequency, period and duty meter fed by timer input-capture events.
// ---------------------------------------------------------------------------
// Each event item (capture count plus accumulated overflow ticks) gives one
// result item: frequency in 0.01 Hz, period and high/low times in 10 ns units
// (saturated at 2^32-1) and duties in 0.01 %, all truncated. Items are taken
// one at a time. Each quotient is loaded, then started on the shared
// restoring divider, which yields one quotient bit per cycle (34 bits for
// the frequency, 33 per time, 14 per duty); simple mode stops after the
// period. A time whose quotient would not fit skips its division; an
// invalid measurement skips all quotients and gives zeros. The next event
// is taken while a finished result still waits in the output register.
// Configuration may be written only while no item is in flight.
module pwm_input_capture_meter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwmicm_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pwmicm_pkg::CLK_W-1:0]      cfg_data,
	pwmicm_evt_if.sink                        evt,
	pwmicm_res_if.source                      res
);

	pwmicm_pkg::cmd_t  cmd;
	pwmicm_pkg::sts_t  sts;

	// Sequencer
	pwmicm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic and storage
	pwmicm_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.capture_count      (evt.capture_count),
		.overflow_ticks     (evt.overflow_ticks),
		.res_ready          (res.ready),
		.res_valid          (res.valid),
		.result_valid       (res.result_valid),
		.frequency_centihz  (res.frequency_centihz),
		.period_10ns        (res.period_10ns),
		.high_time_10ns     (res.high_time_10ns),
		.low_time_10ns      (res.low_time_10ns),
		.high_duty_centipct (res.high_duty_centipct),
		.low_duty_centipct  (res.low_duty_centipct),
		.next_edge_rising   (res.next_edge_rising),
		.cmd                (cmd),
		.sts                (sts)
	);

endmodule

// ===== rtl/pwmicm_chk.sv =====
// ---------------------------------------------------------------------------
// pwmicm_chk
// Port-level checks of the capture meter, bound to the top level.
// ---------------------------------------------------------------------------
`include "pwm_input_capture_meter_macros.svh"

module pwmicm_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              evt_valid,
	input  logic                              evt_ready,
	input  logic                              res_valid,
	input  logic                              res_ready,
	input  logic                              result_valid,
	input  logic [pwmicm_pkg::FREQ_W-1:0]     freq,
	input  logic [pwmicm_pkg::TIME_W-1:0]     period,
	input  logic [pwmicm_pkg::TIME_W-1:0]     high_t,
	input  logic [pwmicm_pkg::TIME_W-1:0]     low_t,
	input  logic [pwmicm_pkg::DUTY_W-1:0]     hduty,
	input  logic [pwmicm_pkg::DUTY_W-1:0]     lduty,
	input  logic                              next_edge
);

	logic [pwmicm_pkg::DUTY_W:0]  duty_sum;
	logic                         meas_zero;

	assign duty_sum  = {1'b0, hduty} + {1'b0, lduty};
	assign meas_zero = (freq == '0) && (period == '0) && (high_t == '0)
		&& (low_t == '0) && (hduty == '0) && (lduty == '0);

	// A stalled result item holds
	`PWMICM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(freq) && $stable(period) && $stable(high_t)
		&& $stable(low_t) && $stable(hduty) && $stable(lduty)
		&& $stable(result_valid) && $stable(next_edge), "result changed while stalled")

	// An invalid measurement carries zeros only
	`PWMICM_ASSERT_NOW(a_invalid_zero, res_valid && !result_valid, meas_zero,
		"invalid result with nonzero fields")

	// High and low duty split the period to within one truncation step
	`PWMICM_ASSERT_NOW(a_duty_sum, res_valid && result_valid && (duty_sum != '0),
		(duty_sum <= 15'd10000) && (duty_sum >= 15'd9999), "duties do not add up")

	// One item at a time: no event is taken right after another
	`PWMICM_ASSERT_NEXT(a_one_item, evt_valid && evt_ready, !evt_ready,
		"event accepted while busy")

endmodule

bind pwm_input_capture_meter pwmicm_chk u_pwmicm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_valid (res.result_valid),
	.freq         (res.frequency_centihz),
	.period       (res.period_10ns),
	.high_t       (res.high_time_10ns),
	.low_t        (res.low_time_10ns),
	.hduty        (res.high_duty_centipct),
	.lduty        (res.low_duty_centipct),
	.next_edge    (res.next_edge_rising)
);
